// ===== hdl/crkt_pkg.sv =====
package crkt_pkg;

  localparam int MAX_KEYS = 8;
  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = 6;
  localparam int SCAN_W = IDX_W + 1;
  localparam int POS_W = 17;
  localparam int FRAC_W = 16;
  localparam int COLOR_W = 32;
  localparam int CHAN_W = 8;
  localparam int MODE_W = 3;
  localparam int KIDX_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int SORT_PHASES = MAX_KEYS;
  localparam int SORT_CNT_W = $clog2(SORT_PHASES);

  localparam logic [POS_W-1:0] POS_ONE = 17'd65536;
  localparam logic [POS_W-1:0] POS_LOW = 17'd1311;
  localparam logic [POS_W-1:0] POS_HIGH = 17'd64225;
  localparam logic [COLOR_W-1:0] START_RESET = 32'hFF000000;
  localparam logic [COLOR_W-1:0] END_RESET = 32'hFFFFFFFF;

  localparam logic [MODE_W-1:0] MODE_EVAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INIT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_SORT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan_init;
    logic scan_step;
    logic take_a;
    logic take_i;
    logic div_init;
    logic div_step;
    logic blend;
    logic sort_init;
    logic sort_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_eval;
    logic need_sort;
    logic scan_end;
    logic scan_hit;
    logic scan_exact;
    logic div_last;
    logic sort_last;
  } status_t;

endpackage

// ===== hdl/crkt_in_if.sv =====
interface crkt_in_if;
  import crkt_pkg::*;

  logic valid;
  logic ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0] position;
  logic [KIDX_W-1:0] key_index;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, mode, position, key_index, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, mode, position, key_index, red, green, blue, alpha,
                output ready);
endinterface

// ===== hdl/crkt_out_if.sv =====
interface crkt_out_if;
  import crkt_pkg::*;

  logic valid;
  logic ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic accepted;
  logic [CNT_W-1:0] key_total;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, accepted,
                  key_total, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, accepted,
                key_total, output ready);
endinterface

// ===== hdl/crkt_ctrl.sv =====
module crkt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  crkt_pkg::status_t status,
  output crkt_pkg::cmd_t cmd
);
  import crkt_pkg::*;

  state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.apply = 1'b1;
        if (status.is_eval) begin
          cmd.scan_init = 1'b1;
          state_next = ST_SCAN;
        end else if (status.need_sort) begin
          cmd.sort_init = 1'b1;
          state_next = ST_SORT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (status.scan_end) begin
          cmd.take_a = 1'b1;
          state_next = ST_FIN;
        end else if (status.scan_hit && status.scan_exact) begin
          cmd.take_i = 1'b1;
          state_next = ST_FIN;
        end else if (status.scan_hit) begin
          cmd.div_init = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_BLEND;
      end
      ST_BLEND: begin
        cmd.blend = 1'b1;
        state_next = ST_FIN;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        if (status.sort_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// ===== hdl/crkt_dp.sv =====
module crkt_dp (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [crkt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crkt_pkg::COLOR_W-1:0] cfg_data,
  input  logic [crkt_pkg::MODE_W-1:0] in_mode,
  input  logic [crkt_pkg::POS_W-1:0] in_position,
  input  logic [crkt_pkg::KIDX_W-1:0] in_key_index,
  input  logic [crkt_pkg::COLOR_W-1:0] in_color,
  input  crkt_pkg::cmd_t cmd,
  output crkt_pkg::status_t status,
  output logic [crkt_pkg::COLOR_W-1:0] out_color,
  output logic out_ok,
  output logic [crkt_pkg::CNT_W-1:0] out_count
);
  import crkt_pkg::*;

  logic [COLOR_W-1:0] start_color, end_color;
  logic [POS_W-1:0] kpos [MAX_KEYS];
  logic [POS_W-1:0] kpos_next [MAX_KEYS];
  logic [COLOR_W-1:0] kcol [MAX_KEYS];
  logic [COLOR_W-1:0] kcol_next [MAX_KEYS];
  logic [CNT_W-1:0] kcnt, kcnt_next;

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0] t_r;
  logic [KIDX_W-1:0] idx_r;
  logic [COLOR_W-1:0] col_r;
  logic [POS_W-1:0] clamped;
  logic interior, op_ok;

  logic [SCAN_W-1:0] scan_i;
  logic [POS_W-1:0] pos_i;
  logic [COLOR_W-1:0] col_i;
  logic [POS_W-1:0] pa;
  logic [COLOR_W-1:0] ca, cb;
  logic [POS_W-1:0] den, rem;
  logic [POS_W:0] rem2;
  logic rem_ge;
  logic [FRAC_W-1:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SORT_CNT_W-1:0] sort_cnt;
  logic [COLOR_W-1:0] blended;
  logic [COLOR_W-1:0] res_r;
  logic ok_r;
  logic sorted;

  // item decode
  always_comb begin
    if (t_r < POS_LOW) clamped = POS_LOW;
    else if (t_r > POS_HIGH) clamped = POS_HIGH;
    else clamped = t_r;
    interior = (idx_r != '0) && (kcnt >= CNT_W'(2)) &&
               ({1'b0, idx_r} < kcnt - CNT_W'(1)) && (32'(idx_r) < MAX_KEYS);
    case (mode_r)
      MODE_EVAL: op_ok = 1'b1;
      MODE_ADD: op_ok = (kcnt < CNT_W'(MAX_KEYS));
      MODE_MOVE: op_ok = interior;
      MODE_REMOVE: op_ok = interior;
      MODE_INIT: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  // key table update
  always_comb begin
    kpos_next = kpos;
    kcol_next = kcol;
    kcnt_next = kcnt;
    if (cmd.apply && op_ok) begin
      case (mode_r)
        MODE_ADD: begin
          kpos_next[kcnt[IDX_W-1:0]] = clamped;
          kcol_next[kcnt[IDX_W-1:0]] = col_r;
          kcnt_next = kcnt + CNT_W'(1);
        end
        MODE_MOVE: begin
          kpos_next[idx_r[IDX_W-1:0]] = clamped;
        end
        MODE_REMOVE: begin
          for (int j = 0; j < MAX_KEYS - 1; j++) begin
            if (CNT_W'(j) >= {1'b0, idx_r} && CNT_W'(j) < kcnt - CNT_W'(1)) begin
              kpos_next[j] = kpos[j+1];
              kcol_next[j] = kcol[j+1];
            end
          end
          kcnt_next = kcnt - CNT_W'(1);
        end
        MODE_INIT: begin
          kpos_next[0] = '0;
          kpos_next[1] = POS_ONE;
          kcol_next[0] = start_color;
          kcol_next[1] = end_color;
          kcnt_next = CNT_W'(2);
        end
        default: begin
        end
      endcase
    end else if (cmd.sort_step) begin
      // odd-even transposition, strict compare keeps equal keys in order
      for (int j = 0; j < MAX_KEYS - 1; j++) begin
        if (1'(j) == sort_cnt[0] && CNT_W'(j + 1) < kcnt && kpos[j] > kpos[j+1]) begin
          kpos_next[j] = kpos[j+1];
          kpos_next[j+1] = kpos[j];
          kcol_next[j] = kcol[j+1];
          kcol_next[j+1] = kcol[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color <= START_RESET;
      end_color <= END_RESET;
      for (int j = 0; j < MAX_KEYS; j++) begin
        kpos[j] <= '0;
        kcol[j] <= '0;
      end
      kpos[1] <= POS_ONE;
      kcol[0] <= START_RESET;
      kcol[1] <= END_RESET;
      kcnt <= CNT_W'(2);
    end else begin
      if (cfg_we && cfg_index == REG_START_COLOR) start_color <= cfg_data;
      if (cfg_we && cfg_index == REG_END_COLOR) end_color <= cfg_data;
      kpos <= kpos_next;
      kcol <= kcol_next;
      kcnt <= kcnt_next;
    end
  end

  // scan, division and blend
  assign pos_i = kpos[scan_i[IDX_W-1:0]];
  assign col_i = kcol[scan_i[IDX_W-1:0]];
  assign rem2 = {rem, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den};

  always_comb begin
    logic [CHAN_W-1:0] a, b;
    logic [POS_W-1:0] wa;
    logic [25:0] v;
    blended = '0;
    wa = POS_ONE - {1'b0, quo};
    for (int s = 0; s < COLOR_W / CHAN_W; s++) begin
      a = ca[s*CHAN_W +: CHAN_W];
      b = cb[s*CHAN_W +: CHAN_W];
      v = 26'(a) * 26'(wa) + 26'(b) * 26'({1'b0, quo});
      blended[s*CHAN_W +: CHAN_W] = v[FRAC_W +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
      div_cnt <= '0;
      sort_cnt <= '0;
    end else begin
      if (cmd.scan_init) scan_i <= '0;
      else if (cmd.scan_step) scan_i <= scan_i + SCAN_W'(1);
      if (cmd.div_init) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (cmd.sort_init) sort_cnt <= '0;
      else if (cmd.sort_step) sort_cnt <= sort_cnt + SORT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      t_r <= in_position;
      idx_r <= in_key_index;
      col_r <= in_color;
      res_r <= '0;
      ok_r <= 1'b0;
    end
    if (cmd.apply) ok_r <= op_ok;
    if (cmd.scan_step) begin
      pa <= pos_i;
      ca <= col_i;
    end
    if (cmd.take_a) res_r <= ca;
    if (cmd.take_i) res_r <= col_i;
    if (cmd.div_init) begin
      den <= pos_i - pa;
      rem <= t_r - pa;
      cb <= col_i;
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? POS_W'(rem2 - {1'b0, den}) : POS_W'(rem2);
      quo <= {quo[FRAC_W-2:0], rem_ge};
    end
    if (cmd.blend) res_r <= blended;
    if (cmd.out_load) begin
      out_color <= res_r;
      out_ok <= ok_r;
      out_count <= kcnt;
    end
  end

  always_comb begin
    status.is_eval = (mode_r == MODE_EVAL);
    status.need_sort = ((mode_r == MODE_ADD) || (mode_r == MODE_MOVE)) && op_ok;
    status.scan_end = ({{(CNT_W-SCAN_W){1'b0}}, scan_i} == kcnt);
    status.scan_hit = (pos_i >= t_r);
    status.scan_exact = (pos_i == t_r) || (scan_i == '0);
    status.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    status.sort_last = (sort_cnt == SORT_CNT_W'(SORT_PHASES - 1));
  end

  always_comb begin
    sorted = 1'b1;
    for (int j = 0; j < MAX_KEYS - 1; j++) begin
      if (CNT_W'(j + 1) < kcnt && kpos[j] > kpos[j+1]) sorted = 1'b0;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    kcnt >= CNT_W'(2) && kcnt <= CNT_W'(MAX_KEYS))
    else $error("key count out of range");
  a_sorted_at_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sorted)
    else $error("key table not sorted when result is issued");
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem < den)
    else $error("division remainder not below divisor");
  a_div_has_gap: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> pos_i > pa && t_r > pa)
    else $error("bracketing keys do not enclose position");
`endif

endmodule

// ===== hdl/color_ramp_key_table.sv =====
// channel   dir  handshake         payload
// in_ch     in   valid / ready     mode, position, key_index, red, green, blue, alpha
// out_ch    out  valid / ready     out_red..out_alpha, accepted, key_total
// cfg       in   cfg_we only       cfg_index, cfg_data (0 start color, 1 end color)
//
// one item at a time: ready only while the controller is idle
// eval: decode, a scan over up to 8 keys, a restoring divide for 16 fraction bits, a blend
// add and move: decode, then eight odd-even sort phases over the table
// remove, init, rejected: no scan or sort; eval on a key or past the last: no divide
// the result register frees the engine; a stalled out_ch holds the next result in fin
// reset (rst, synchronous) loads the two end keys from the reset colors
module color_ramp_key_table (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [crkt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crkt_pkg::COLOR_W-1:0] cfg_data,
  crkt_in_if.sink in_ch,
  crkt_out_if.source out_ch
);
  import crkt_pkg::*;

  cmd_t cmd;
  status_t status;
  logic [COLOR_W-1:0] in_color;
  logic [COLOR_W-1:0] out_color;

  // key color packing: red in the low byte, alpha in the high byte
  assign in_color = {in_ch.alpha, in_ch.blue, in_ch.green, in_ch.red};

  // sequencer: fetch, decode, scan / divide / blend or sort, then result
  crkt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status(status),
    .cmd(cmd)
  );

  // key table, restoring divider, channel blend and result register
  crkt_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_mode(in_ch.mode),
    .in_position(in_ch.position),
    .in_key_index(in_ch.key_index),
    .in_color(in_color),
    .cmd(cmd),
    .status(status),
    .out_color(out_color),
    .out_ok(out_ch.accepted),
    .out_count(out_ch.key_total)
  );

  // unpack result color to the channel fields
  assign out_ch.out_red = out_color[0 +: CHAN_W];
  assign out_ch.out_green = out_color[CHAN_W +: CHAN_W];
  assign out_ch.out_blue = out_color[2*CHAN_W +: CHAN_W];
  assign out_ch.out_alpha = out_color[3*CHAN_W +: CHAN_W];

endmodule
